@@ sv/mae_pkg.sv @@
// Shared types, constants and microcode table for the moving-average envelope block.
// Used by every module of the block; depends on nothing else.
package mae_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W   = 12;
    localparam int AVG_W      = 12;
    localparam int OFS_W      = 13;
    localparam int CMP_W      = 10;
    localparam int POL_W      = 2;
    localparam int QUO_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Parameter defaults
    localparam int WINDOW_LEN_DEF = 16;
    localparam int PWM_PERIOD_DEF = 1000;

    // Register reset values
    localparam int MEAN_RST = 2048;
    localparam int PEAK_RST = 1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_EN = 2'd2;

    // Polarity codes
    localparam logic [POL_W-1:0] POL_IDLE = 2'd0;
    localparam logic [POL_W-1:0] POL_POS  = 2'd1;
    localparam logic [POL_W-1:0] POL_NEG  = 2'd2;

    typedef logic [3:0] op_t;
    typedef logic [2:0] cond_t;
    typedef logic [3:0] step_t;

    // Datapath operations
    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_ACCEPT   = 4'd1;
    localparam op_t OP_UPDATE   = 4'd2;
    localparam op_t OP_DIFF     = 4'd3;
    localparam op_t OP_DIV_STEP = 4'd4;
    localparam op_t OP_AVG      = 4'd5;
    localparam op_t OP_OFFSET   = 4'd6;
    localparam op_t OP_SCALE    = 4'd7;
    localparam op_t OP_PEAK     = 4'd8;
    localparam op_t OP_CMP      = 4'd9;
    localparam op_t OP_EMIT     = 4'd10;
    localparam op_t OP_RCP_MUL  = 4'd11;
    localparam op_t OP_RCP_REM  = 4'd12;

    // Jump conditions
    localparam cond_t C_NEVER    = 3'd0;
    localparam cond_t C_ALWAYS   = 3'd1;
    localparam cond_t C_NO_IN    = 3'd2;
    localparam cond_t C_DIV_MORE = 3'd3;
    localparam cond_t C_OUT_BUSY = 3'd4;

    // Jump targets
    localparam step_t S_ACCEPT  = 4'd0;
    localparam step_t S_UPDATE  = 4'd1;
    localparam step_t S_DIFF    = 4'd2;
    localparam step_t S_AVG_MUL = 4'd3;
    localparam step_t S_AVG_REM = 4'd4;
    localparam step_t S_AVG     = 4'd5;
    localparam step_t S_OFS_MUL = 4'd6;
    localparam step_t S_OFS_REM = 4'd7;
    localparam step_t S_OFFSET  = 4'd8;
    localparam step_t S_SCALE   = 4'd9;
    localparam step_t S_PEAK    = 4'd10;
    localparam step_t S_DIV_CMP = 4'd11;
    localparam step_t S_CMP     = 4'd12;
    localparam step_t S_EMIT    = 4'd13;
    localparam step_t S_WRAP    = 4'd14;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic in_take;
        logic out_free;
        logic div_more;
    } dp_status_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Microcode program: a jump is taken when the condition holds, else fall through
    function automatic uword_t ucode_rom(step_t addr);
        uword_t w;
        unique case (addr)
            S_ACCEPT:  w = '{op: OP_ACCEPT,   cond: C_NO_IN,    target: S_ACCEPT};
            S_UPDATE:  w = '{op: OP_UPDATE,   cond: C_NEVER,    target: S_ACCEPT};
            S_DIFF:    w = '{op: OP_DIFF,     cond: C_NEVER,    target: S_ACCEPT};
            S_AVG_MUL: w = '{op: OP_RCP_MUL,  cond: C_NEVER,    target: S_ACCEPT};
            S_AVG_REM: w = '{op: OP_RCP_REM,  cond: C_NEVER,    target: S_ACCEPT};
            S_AVG:     w = '{op: OP_AVG,      cond: C_NEVER,    target: S_ACCEPT};
            S_OFS_MUL: w = '{op: OP_RCP_MUL,  cond: C_NEVER,    target: S_ACCEPT};
            S_OFS_REM: w = '{op: OP_RCP_REM,  cond: C_NEVER,    target: S_ACCEPT};
            S_OFFSET:  w = '{op: OP_OFFSET,   cond: C_NEVER,    target: S_ACCEPT};
            S_SCALE:   w = '{op: OP_SCALE,    cond: C_NEVER,    target: S_ACCEPT};
            S_PEAK:    w = '{op: OP_PEAK,     cond: C_NEVER,    target: S_ACCEPT};
            S_DIV_CMP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE, target: S_DIV_CMP};
            S_CMP:     w = '{op: OP_CMP,      cond: C_NEVER,    target: S_ACCEPT};
            S_EMIT:    w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: S_EMIT};
            S_WRAP:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_ACCEPT};
            default:   w = '{op: OP_NOP,      cond: C_ALWAYS,   target: S_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

@@ sv/mae_sequencer.sv @@
// Microcode sequencer: step counter, control-word fetch and conditional jumps.
// Depends on mae_pkg for the control word layout and the program table.
module mae_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  mae_pkg::dp_status_t status,
    output mae_pkg::op_t        op
);
    import mae_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uword;
    logic   jump;

    // Fetch the current control word
    assign uword = ucode_rom(step_reg);
    assign op    = uword.op;

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uword.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !status.in_take;
            C_DIV_MORE: jump = status.div_more;
            C_OUT_BUSY: jump = !status.out_free;
            default:    jump = 1'b0;
        endcase
        step_next = jump ? uword.target : step_t'(step_reg + 1'b1);
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_ACCEPT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ sv/mae_divider.sv @@
// Restoring divider, one quotient bit per cycle, QUO_W bits per division.
// Depends on mae_pkg; the dividend must stay below divisor * 2**QUO_W.
module mae_divider #(
    parameter int REM_W = 22,
    parameter int DVS_W = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mae_pkg::div_ctrl_t        ctrl,
    input  logic [REM_W-1:0]          dividend,
    input  logic [DVS_W-1:0]          divisor,
    output logic [mae_pkg::QUO_W-1:0] quotient,
    output logic                      more
);
    import mae_pkg::*;

    localparam int DS_W  = DVS_W + QUO_W - 1;
    localparam int CW    = (REM_W > DS_W) ? REM_W : DS_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [DS_W-1:0]  dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ge;

    // Trial compare of the remainder against the shifted divisor
    assign ge       = CW'(rem_reg) >= CW'(dsh_reg);
    assign quotient = quo_reg;
    assign more     = cnt_reg != CNT_W'(1);

    // Hold the remaining step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= CNT_W'(QUO_W);
        end
        else if (ctrl.step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Subtract and shift
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {(QUO_W - 1){1'b0}}};
            quo_reg <= '0;
        end
        else if (ctrl.step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - REM_W'(dsh_reg);
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

endmodule

@@ sv/mae_datapath.sv @@
// Datapath: sample window memory, running sum, offset, PWM scaling and output register.
// Depends on mae_pkg and mae_divider; driven by the operation code from mae_sequencer.
module mae_datapath #(
    parameter int WINDOW_LEN = mae_pkg::WINDOW_LEN_DEF,
    parameter int PWM_PERIOD = mae_pkg::PWM_PERIOD_DEF,
    parameter int SUM_W      = mae_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mae_pkg::op_t                      op,
    output mae_pkg::dp_status_t               status,
    input  logic [SUM_W-1:0]                  mean_scaled,
    input  logic [mae_pkg::SAMPLE_W-1:0]      peak,
    input  logic                              mod_en,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mae_pkg::SAMPLE_W-1:0]      sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mae_pkg::AVG_W-1:0]         average,
    output logic signed [mae_pkg::OFS_W-1:0]  offset_value,
    output logic [mae_pkg::CMP_W-1:0]         compare_value,
    output logic [mae_pkg::CMP_W-1:0]         off_time,
    output logic [mae_pkg::POL_W-1:0]         polarity
);
    import mae_pkg::*;

    localparam int PTR_W   = $clog2(WINDOW_LEN);
    localparam int PER_W   = $clog2(PWM_PERIOD + 1);
    localparam int PROD_W  = SAMPLE_W + PER_W;
    localparam int DIFF_W  = SUM_W + 1;
    localparam int RCP_W   = SAMPLE_W + 1;
    localparam int RPROD_W = SUM_W + RCP_W;
    localparam int OV_W    = (PROD_W > SAMPLE_W + QUO_W) ? PROD_W : SAMPLE_W + QUO_W;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0] LEN_S     = SUM_W'(WINDOW_LEN);
    localparam logic [RCP_W-1:0] RECIP     = RCP_W'((1 << SUM_W) / WINDOW_LEN);
    localparam logic [PER_W-1:0] PERIOD_P  = PER_W'(PWM_PERIOD);
    localparam logic [CMP_W-1:0] PERIOD_C  = CMP_W'(PWM_PERIOD);
    localparam logic [QUO_W-1:0] PERIOD_Q  = QUO_W'(PWM_PERIOD);

    // Window memory and its per-entry valid bits
    logic [SAMPLE_W-1:0]   mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] valid_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_valid_reg;
    logic [SAMPLE_W-1:0]   samp_reg;
    logic [SUM_W-1:0]      sum_reg;

    // Working registers
    logic signed [DIFF_W-1:0] diff_reg;
    logic [AVG_W-1:0]         avg_reg;
    logic [OFS_W-1:0]         ofs_reg;
    logic [SAMPLE_W-1:0]      mag_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     ovf_reg;
    logic [CMP_W-1:0]         cmp_reg;
    logic [SUM_W-1:0]         rx_reg;
    logic [QUO_W-1:0]         est_reg;
    logic [SUM_W-1:0]         rem_reg;

    // Output register
    logic                     out_valid_reg;
    logic [AVG_W-1:0]         out_avg_reg;
    logic [OFS_W-1:0]         out_ofs_reg;
    logic [CMP_W-1:0]         out_cmp_reg;
    logic [CMP_W-1:0]         out_off_reg;
    logic [POL_W-1:0]         out_pol_reg;

    logic                in_take;
    logic                out_free;
    logic                emit_fire;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    diff_mag;
    logic [OFS_W-1:0]    quo_ext;
    logic [SAMPLE_W-1:0] peak_eff;
    logic                diff_pos;
    logic [RPROD_W-1:0]  rcp_prod;
    logic [QUO_W-1:0]    rcp_quo;
    div_ctrl_t           div_ctrl;
    logic [QUO_W-1:0]    quo;
    logic                div_more;

    // Handshake and status toward the sequencer
    assign in_stall  = (op != OP_ACCEPT);
    assign in_take   = (op == OP_ACCEPT) && in_valid;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_fire = (op == OP_EMIT) && out_free;
    assign status    = '{in_take: in_take, out_free: out_free, div_more: div_more};

    // Derived values
    assign old_sample = rd_valid_reg ? rd_data_reg : '0;
    assign diff_mag   = diff_reg[DIFF_W-1] ? SUM_W'(-diff_reg) : SUM_W'(diff_reg);
    assign diff_pos   = !diff_reg[DIFF_W-1] && (diff_reg != '0);
    assign peak_eff   = (peak == '0) ? SAMPLE_W'(1) : peak;

    // Division by the window length: reciprocal estimate, low by at most one
    assign rcp_prod = {{RCP_W{1'b0}}, rx_reg} * {{SUM_W{1'b0}}, RECIP};
    assign rcp_quo  = est_reg + {{(QUO_W - 1){1'b0}}, (rem_reg >= LEN_S)};
    assign quo_ext  = {1'b0, rcp_quo};

    // Divider serves only the duty scaling by the peak register
    assign div_ctrl = '{load: (op == OP_PEAK), step: (op == OP_DIV_STEP)};

    mae_divider #(
        .REM_W (PROD_W),
        .DVS_W (SAMPLE_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (peak_eff),
        .quotient (quo),
        .more     (div_more)
    );

    // Window memory: read the oldest entry on accept, replace it on update
    always_ff @(posedge clk)
    begin
        if (op == OP_UPDATE)
        begin
            mem[ptr_reg] <= samp_reg;
        end
        if (op == OP_ACCEPT)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    // Window control state: valid bits, pointer, running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            ptr_reg      <= '0;
            sum_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_ACCEPT)
            begin
                rd_valid_reg <= valid_reg[ptr_reg];
            end
            if (op == OP_UPDATE)
            begin
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                sum_reg            <= sum_reg - SUM_W'(old_sample) + SUM_W'(samp_reg);
            end
        end
    end

    // Working registers of the computation
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            samp_reg <= sample;
        end
        case (op)
            OP_DIFF:
            begin
                diff_reg <= $signed({1'b0, sum_reg}) - $signed({1'b0, mean_scaled});
                rx_reg   <= sum_reg;
            end
            OP_RCP_MUL:
            begin
                est_reg <= rcp_prod[SUM_W +: QUO_W];
            end
            OP_RCP_REM:
            begin
                rem_reg <= rx_reg - SUM_W'(est_reg) * LEN_S;
            end
            OP_AVG:
            begin
                avg_reg <= rcp_quo;
                rx_reg  <= diff_mag;
            end
            OP_OFFSET:
            begin
                mag_reg <= rcp_quo;
                ofs_reg <= diff_reg[DIFF_W-1] ? (~quo_ext + 1'b1) : quo_ext;
            end
            OP_SCALE:
            begin
                prod_reg <= {{PER_W{1'b0}}, mag_reg} * {{SAMPLE_W{1'b0}}, PERIOD_P};
            end
            OP_PEAK:
            begin
                ovf_reg <= OV_W'(prod_reg) >= OV_W'({peak_eff, {QUO_W{1'b0}}});
            end
            OP_CMP:
            begin
                cmp_reg <= (ovf_reg || (quo > PERIOD_Q)) ? PERIOD_C : CMP_W'(quo);
            end
            default:
            begin
            end
        endcase
    end

    // Output valid: set on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_avg_reg <= avg_reg;
            out_ofs_reg <= ofs_reg;
            out_cmp_reg <= cmp_reg;
            out_off_reg <= PERIOD_C - cmp_reg;
            out_pol_reg <= !mod_en ? POL_IDLE : (diff_pos ? POL_POS : POL_NEG);
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = out_avg_reg;
    assign offset_value  = $signed(out_ofs_reg);
    assign compare_value = out_cmp_reg;
    assign off_time      = out_off_reg;
    assign polarity      = out_pol_reg;

endmodule

@@ sv/moving_average_envelope_pwm.sv @@
// Top level of the moving-average envelope detector with PWM compare output.
// Holds the configuration registers; depends on mae_pkg, mae_sequencer and mae_datapath.
//
// Each accepted 12-bit sample replaces the oldest entry of a WINDOW_LEN-entry
// window (all zeros after reset, tracked by per-entry valid bits, so no clear
// pass is needed) and yields one result: the floor average, the offset from
// signal_mean truncated toward zero, a PWM compare value saturated at
// PWM_PERIOD, its off time and a polarity code. A microcoded sequencer runs
// the work on one sample at a time: the window update, the difference from
// the mean, the reciprocal divisions by the window length for the average
// and the offset, the scaling by PWM_PERIOD, the one-bit-per-cycle divider
// pass for the duty scaling by the peak register, the compare saturation
// and the emit step. The next sample is taken while a result still waits in
// the output register; a second result waits at the emit step until the
// first is taken.
// Configuration writes are always accepted and must be made while idle.
module moving_average_envelope_pwm #(
    parameter int WINDOW_LEN = mae_pkg::WINDOW_LEN_DEF,
    parameter int PWM_PERIOD = mae_pkg::PWM_PERIOD_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mae_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mae_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mae_pkg::SAMPLE_W-1:0]       sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mae_pkg::AVG_W-1:0]          average,
    output logic signed [mae_pkg::OFS_W-1:0]   offset_value,
    output logic [mae_pkg::CMP_W-1:0]          compare_value,
    output logic [mae_pkg::CMP_W-1:0]          off_time,
    output logic [mae_pkg::POL_W-1:0]          polarity
);
    import mae_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);

    logic [SUM_W-1:0]    mean_scaled_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic                mod_en_reg;
    op_t                 op;
    dp_status_t          status;

    assign cfg_ready = 1'b1;

    // Configuration registers; the mean is kept pre-scaled by the window length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_scaled_reg <= SUM_W'(MEAN_RST * WINDOW_LEN);
            peak_reg        <= SAMPLE_W'(PEAK_RST);
            mod_en_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MEAN:   mean_scaled_reg <= SUM_W'(cfg_data) * SUM_W'(WINDOW_LEN);
                CFG_PEAK:   peak_reg        <= cfg_data;
                CFG_MOD_EN: mod_en_reg      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mae_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    mae_datapath #(
        .WINDOW_LEN (WINDOW_LEN),
        .PWM_PERIOD (PWM_PERIOD),
        .SUM_W      (SUM_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .status        (status),
        .mean_scaled   (mean_scaled_reg),
        .peak          (peak_reg),
        .mod_en        (mod_en_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average       (average),
        .offset_value  (offset_value),
        .compare_value (compare_value),
        .off_time      (off_time),
        .polarity      (polarity)
    );

endmodule
